// ===== design/nbgws_pkg.sv =====
// Shared types, codes and fixed-point helpers for the n-body step block.
`default_nettype none

package nbgws_pkg;

    // Input operation codes
    localparam logic OPER_LOAD = 1'b0;
    localparam logic OPER_STEP = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_GRAVITY_GAIN  = 3'd0;
    localparam logic [2:0] CFG_TIME_STEP     = 3'd1;
    localparam logic [2:0] CFG_MIN_DISTANCE  = 3'd2;
    localparam logic [2:0] CFG_ARENA_WIDTH   = 3'd3;
    localparam logic [2:0] CFG_ARENA_HEIGHT  = 3'd4;
    localparam logic [2:0] CFG_BODIES_IN_USE = 3'd5;

    // Configuration reset values
    localparam logic [31:0] RST_GRAVITY_GAIN  = 32'd32768000;
    localparam logic [31:0] RST_TIME_STEP     = 32'd6554;
    localparam logic [9:0]  RST_MIN_DISTANCE  = 10'd5;
    localparam logic [11:0] RST_ARENA_WIDTH   = 12'd1000;
    localparam logic [11:0] RST_ARENA_HEIGHT  = 12'd800;
    localparam logic [4:0]  RST_BODIES_IN_USE = 5'd15;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_GDT,
        OP_GDT_SAT,
        OP_RD_I,
        OP_CAP_I,
        OP_MOV_X,
        OP_MOV_Y,
        OP_RD_J,
        OP_DIFF,
        OP_SQ_X,
        OP_SQ_Y,
        OP_D2,
        OP_N_X,
        OP_N_Y,
        OP_ACC,
        OP_BOUNCE,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   last;
    } dp_cmd_t;

    typedef struct packed {
        logic       skip;
        logic       div_idle;
        logic [4:0] bodies_in_use;
    } dp_stat_t;

    typedef struct packed {
        logic [31:0] pos;
        logic [31:0] vel;
    } axis_t;

    // Saturate a wide signed value to 32 bits
    function automatic logic [31:0] sat_s32(input logic signed [67:0] v);
        if (v > 68'sh7FFFFFFF) begin
            return 32'h7FFFFFFF;
        end else if (v < -68'sh80000000) begin
            return 32'h80000000;
        end else begin
            return v[31:0];
        end
    endfunction

    // Negate with saturation of the most negative value
    function automatic logic [31:0] neg_sat(input logic signed [31:0] v);
        if (v == 32'sh80000000) begin
            return 32'h7FFFFFFF;
        end else begin
            return 32'(-v);
        end
    endfunction

    // Wall check for one axis: reflect velocity, clamp to radius from the wall
    function automatic axis_t bounce_axis(input logic signed [31:0] p,
                                          input logic signed [31:0] v,
                                          input logic [7:0] radius,
                                          input logic [11:0] wall);
        logic signed [33:0] p34;
        logic signed [33:0] r34;
        logic signed [33:0] w34;
        logic signed [33:0] lo_d;
        logic signed [33:0] hi_d;
        logic signed [33:0] wr;
        axis_t res;
        p34 = 34'(p);
        r34 = $signed({10'b0, radius, 16'b0});
        w34 = $signed({6'b0, wall, 16'b0});
        lo_d = p34 - r34;
        hi_d = p34 + r34;
        wr = w34 - r34;
        res.pos = p;
        res.vel = v;
        if (lo_d[33] || hi_d > w34) begin
            res.vel = neg_sat(v);
            res.pos = lo_d[33] ? r34[31:0] : wr[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/nbgws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module nbgws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata_reg
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/nbgws_div.sv =====
// Restoring divider: floor(num * 2^16 / den) saturated at 2^31-1, one bit a cycle.
`default_nettype none

module nbgws_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [64:0] num,
    input  wire logic [63:0] den,
    output logic             busy,
    output logic [30:0]      quo
);

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] rem_reg;
    logic [30:0] lo_reg;
    logic [30:0] q_reg;
    logic [64:0] trial;
    logic        fits;

    // One partial remainder step
    assign trial = {rem_reg, lo_reg[30]};
    assign fits  = trial >= {1'b0, den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            if ({14'b0, num} >= {den, 15'b0}) begin
                busy_reg <= 1'b0;
                q_reg    <= '1;
            end else begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd30;
                rem_reg  <= {14'b0, num[64:15]};
                lo_reg   <= {num[14:0], 16'b0};
                q_reg    <= '0;
            end
        end else if (busy_reg) begin
            rem_reg <= fits ? 64'(trial - {1'b0, den}) : trial[63:0];
            q_reg   <= {q_reg[29:0], fits};
            lo_reg  <= {lo_reg[29:0], 1'b0};
            if (cnt_reg == 5'd0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 5'd1;
            end
        end
    end

    assign busy = busy_reg;
    assign quo  = q_reg;

endmodule

`default_nettype wire

// ===== design/nbgws_dp.sv =====
// Datapath: body stores, configuration registers, shared multiplier, dividers.
`default_nettype none

module nbgws_dp
    import nbgws_pkg::*;
#(
    parameter int MAX_BODIES = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire dp_cmd_t                       cmd,
    input  wire logic [$clog2(MAX_BODIES)-1:0] addr,
    output dp_stat_t                           stat,
    input  wire logic                          cfg_valid,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [31:0]                   cfg_data,
    input  wire logic [3:0]                    s_body_index,
    input  wire logic [7:0]                    s_body_radius,
    input  wire logic [31:0]                   s_body_mass,
    input  wire logic signed [31:0]            s_start_x,
    input  wire logic signed [31:0]            s_start_y,
    input  wire logic signed [31:0]            s_start_vx,
    input  wire logic signed [31:0]            s_start_vy,
    output logic [3:0]                         m_out_index,
    output logic signed [31:0]                 m_out_x,
    output logic signed [31:0]                 m_out_y,
    output logic                               m_last_body
);

    localparam int AW = $clog2(MAX_BODIES);

    // Configuration
    logic [31:0] gain_reg;
    logic [31:0] dt_reg;
    logic [9:0]  md_reg;
    logic [11:0] aw_reg;
    logic [11:0] ah_reg;
    logic [4:0]  biu_reg;

    // Working registers
    logic signed [67:0] prod_reg;
    logic [31:0]        gdt_reg;
    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg;
    logic [7:0]         rad_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic [32:0]        ax_reg, ay_reg;
    logic [31:0]        c_reg;
    logic [64:0]        sx_reg;
    logic [63:0]        d2_reg;
    logic [3:0]         oidx_reg;
    logic [31:0]        ox_reg, oy_reg;
    logic               olast_reg;

    logic signed [33:0] ma, mb;
    logic [63:0]        pos_rd, vel_rd;
    logic [39:0]        rm_rd;
    logic               load_we, bnc_we;
    logic [AW-1:0]      waddr;
    logic signed [32:0] dx_next, dy_next;
    logic [65:0]        d2_sum;
    logic [19:0]        md_sq;
    logic [63:0]        lim;
    logic [30:0]        qx, qy;
    logic               busy_x, busy_y;
    logic signed [67:0] gx, gy;
    axis_t              bx, by;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= RST_GRAVITY_GAIN;
            dt_reg   <= RST_TIME_STEP;
            md_reg   <= RST_MIN_DISTANCE;
            aw_reg   <= RST_ARENA_WIDTH;
            ah_reg   <= RST_ARENA_HEIGHT;
            biu_reg  <= RST_BODIES_IN_USE;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_GRAVITY_GAIN:  gain_reg <= cfg_data;
                CFG_TIME_STEP:     dt_reg   <= cfg_data;
                CFG_MIN_DISTANCE:  md_reg   <= cfg_data[9:0];
                CFG_ARENA_WIDTH:   aw_reg   <= cfg_data[11:0];
                CFG_ARENA_HEIGHT:  ah_reg   <= cfg_data[11:0];
                CFG_BODIES_IN_USE: biu_reg  <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Body store write port: loads, and the write-back of an updated body
    assign load_we = (cmd.op == OP_LOAD) && (32'(s_body_index) < MAX_BODIES);
    assign bnc_we  = (cmd.op == OP_BOUNCE);
    assign waddr   = load_we ? AW'(s_body_index) : addr;
    assign bx      = bounce_axis(px_reg, vx_reg, rad_reg, aw_reg);
    assign by      = bounce_axis(py_reg, vy_reg, rad_reg, ah_reg);

    nbgws_ram #(.WIDTH(64), .DEPTH(MAX_BODIES)) u_pos_ram (
        .aclk      (aclk),
        .we        (load_we || bnc_we),
        .waddr     (waddr),
        .wdata     (load_we ? {s_start_x, s_start_y} : {bx.pos, by.pos}),
        .raddr     (addr),
        .rdata_reg (pos_rd)
    );

    nbgws_ram #(.WIDTH(64), .DEPTH(MAX_BODIES)) u_vel_ram (
        .aclk      (aclk),
        .we        (load_we || bnc_we),
        .waddr     (waddr),
        .wdata     (load_we ? {s_start_vx, s_start_vy} : {bx.vel, by.vel}),
        .raddr     (addr),
        .rdata_reg (vel_rd)
    );

    nbgws_ram #(.WIDTH(40), .DEPTH(MAX_BODIES)) u_rm_ram (
        .aclk      (aclk),
        .we        (load_we),
        .waddr     (waddr),
        .wdata     ({s_body_radius, s_body_mass}),
        .raddr     (addr),
        .rdata_reg (rm_rd)
    );

    // Shared multiplier operand select
    always_comb begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            OP_GDT: begin
                ma = {2'b0, gain_reg};
                mb = {2'b0, dt_reg};
            end
            OP_CAP_I: begin
                ma = 34'($signed(vel_rd[63:32]));
                mb = {2'b0, dt_reg};
            end
            OP_MOV_X: begin
                ma = 34'(vy_reg);
                mb = {2'b0, dt_reg};
            end
            OP_DIFF: begin
                ma = {2'b0, gdt_reg};
                mb = {2'b0, rm_rd[31:0]};
            end
            OP_SQ_X: begin
                ma = {1'b0, ax_reg};
                mb = {1'b0, ax_reg};
            end
            OP_SQ_Y: begin
                ma = {1'b0, ay_reg};
                mb = {1'b0, ay_reg};
            end
            OP_D2: begin
                ma = {1'b0, ax_reg};
                mb = {2'b0, c_reg};
            end
            OP_N_X: begin
                ma = {1'b0, ay_reg};
                mb = {2'b0, c_reg};
            end
            default: ;
        endcase
    end

    // Pair geometry
    assign dx_next = 33'($signed(pos_rd[63:32])) - 33'(px_reg);
    assign dy_next = 33'($signed(pos_rd[31:0])) - 33'(py_reg);
    assign d2_sum  = {1'b0, sx_reg} + {1'b0, prod_reg[64:0]};
    assign md_sq   = {10'b0, md_reg} * {10'b0, md_reg};
    assign lim     = {12'b0, md_sq, 32'b0};

    // Signed velocity gains from the quotients
    assign gx = dx_reg[32] ? -68'($signed({1'b0, qx})) : 68'($signed({1'b0, qx}));
    assign gy = dy_reg[32] ? -68'($signed({1'b0, qy})) : 68'($signed({1'b0, qy}));

    nbgws_div u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.op == OP_N_X),
        .num     (prod_reg[64:0]),
        .den     (d2_reg),
        .busy    (busy_x),
        .quo     (qx)
    );

    nbgws_div u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.op == OP_N_Y),
        .num     (prod_reg[64:0]),
        .den     (d2_reg),
        .busy    (busy_y),
        .quo     (qy)
    );

    // Working register updates per micro-operation
    always_ff @(posedge aclk) begin
        prod_reg <= ma * mb;
        case (cmd.op)
            OP_GDT_SAT: gdt_reg <= (|prod_reg[67:48]) ? '1 : prod_reg[47:16];
            OP_CAP_I: begin
                px_reg  <= pos_rd[63:32];
                py_reg  <= pos_rd[31:0];
                vx_reg  <= vel_rd[63:32];
                vy_reg  <= vel_rd[31:0];
                rad_reg <= rm_rd[39:32];
            end
            OP_MOV_X: px_reg <= sat_s32(68'(px_reg) + (prod_reg >>> 16));
            OP_MOV_Y: py_reg <= sat_s32(68'(py_reg) + (prod_reg >>> 16));
            OP_DIFF: begin
                dx_reg <= dx_next;
                dy_reg <= dy_next;
                ax_reg <= dx_next[32] ? 33'(-dx_next) : dx_next;
                ay_reg <= dy_next[32] ? 33'(-dy_next) : dy_next;
            end
            OP_SQ_X: c_reg <= (|prod_reg[67:48]) ? '1 : prod_reg[47:16];
            OP_SQ_Y: sx_reg <= prod_reg[64:0];
            OP_D2: d2_reg <= (|d2_sum[65:64]) ? '1 : d2_sum[63:0];
            OP_ACC: begin
                vx_reg <= sat_s32(68'(vx_reg) + gx);
                vy_reg <= sat_s32(68'(vy_reg) + gy);
            end
            OP_BOUNCE: begin
                px_reg <= bx.pos;
                vx_reg <= bx.vel;
                py_reg <= by.pos;
                vy_reg <= by.vel;
            end
            OP_EMIT: begin
                oidx_reg  <= 4'(addr);
                ox_reg    <= px_reg;
                oy_reg    <= py_reg;
                olast_reg <= cmd.last;
            end
            default: ;
        endcase
    end

    assign stat.skip          = (d2_reg < lim) || (d2_reg == '0);
    assign stat.div_idle      = !busy_x && !busy_y;
    assign stat.bodies_in_use = biu_reg;

    assign m_out_index = oidx_reg;
    assign m_out_x     = ox_reg;
    assign m_out_y     = oy_reg;
    assign m_last_body = olast_reg;

endmodule

`default_nettype wire

// ===== design/nbgws_ctrl.sv =====
// Controller: sequences loads, the body loop, the pair loop and result hand-off.
`default_nettype none

module nbgws_ctrl
    import nbgws_pkg::*;
#(
    parameter int MAX_BODIES = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_operation,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output dp_cmd_t                            cmd,
    output logic [$clog2(MAX_BODIES)-1:0]      addr,
    input  wire dp_stat_t                      stat
);

    localparam int AW = $clog2(MAX_BODIES);
    localparam int NW = $clog2(MAX_BODIES + 1);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_GDT,
        ST_GDT_SAT,
        ST_RD_I,
        ST_CAP_I,
        ST_MOV_X,
        ST_MOV_Y,
        ST_J,
        ST_DIFF,
        ST_SQ_X,
        ST_SQ_Y,
        ST_D2,
        ST_N_X,
        ST_N_Y,
        ST_WAIT,
        ST_ACC,
        ST_BOUNCE,
        ST_EMIT
    } state_t;

    state_t        state_reg;
    logic [AW-1:0] i_reg;
    logic [AW-1:0] j_reg;
    logic          m_valid_reg;
    logic [NW-1:0] n_bodies;
    logic          i_last, j_last, slot_free, accept;

    // Bodies per step, capped at the store depth
    assign n_bodies  = (32'(stat.bodies_in_use) > MAX_BODIES) ? NW'(MAX_BODIES)
                                                              : NW'(stat.bodies_in_use);
    assign i_last    = (NW'(i_reg) + NW'(1)) == n_bodies;
    assign j_last    = (NW'(j_reg) + NW'(1)) == n_bodies;
    assign slot_free = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    // State, loop counters and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready && !(state_reg == ST_EMIT && slot_free)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept && s_operation == OPER_STEP && n_bodies != '0) begin
                        state_reg <= ST_GDT;
                        i_reg     <= '0;
                    end
                end
                ST_GDT:     state_reg <= ST_GDT_SAT;
                ST_GDT_SAT: state_reg <= ST_RD_I;
                ST_RD_I:    state_reg <= ST_CAP_I;
                ST_CAP_I:   state_reg <= ST_MOV_X;
                ST_MOV_X:   state_reg <= ST_MOV_Y;
                ST_MOV_Y: begin
                    state_reg <= ST_J;
                    j_reg     <= '0;
                end
                ST_J: begin
                    if (j_reg != i_reg) begin
                        state_reg <= ST_DIFF;
                    end else if (j_last) begin
                        state_reg <= ST_BOUNCE;
                    end else begin
                        j_reg <= j_reg + AW'(1);
                    end
                end
                ST_DIFF: state_reg <= ST_SQ_X;
                ST_SQ_X: state_reg <= ST_SQ_Y;
                ST_SQ_Y: state_reg <= ST_D2;
                ST_D2:   state_reg <= ST_N_X;
                ST_N_X: begin
                    if (!stat.skip) begin
                        state_reg <= ST_N_Y;
                    end else if (j_last) begin
                        state_reg <= ST_BOUNCE;
                    end else begin
                        state_reg <= ST_J;
                        j_reg     <= j_reg + AW'(1);
                    end
                end
                ST_N_Y: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (stat.div_idle) begin
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (j_last) begin
                        state_reg <= ST_BOUNCE;
                    end else begin
                        state_reg <= ST_J;
                        j_reg     <= j_reg + AW'(1);
                    end
                end
                ST_BOUNCE: state_reg <= ST_EMIT;
                ST_EMIT: begin
                    if (slot_free) begin
                        m_valid_reg <= 1'b1;
                        if (i_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_RD_I;
                            i_reg     <= i_reg + AW'(1);
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath command for the current state
    always_comb begin
        cmd.op   = OP_IDLE;
        cmd.last = i_last;
        case (state_reg)
            ST_IDLE:    cmd.op = (accept && s_operation == OPER_LOAD) ? OP_LOAD : OP_IDLE;
            ST_GDT:     cmd.op = OP_GDT;
            ST_GDT_SAT: cmd.op = OP_GDT_SAT;
            ST_RD_I:    cmd.op = OP_RD_I;
            ST_CAP_I:   cmd.op = OP_CAP_I;
            ST_MOV_X:   cmd.op = OP_MOV_X;
            ST_MOV_Y:   cmd.op = OP_MOV_Y;
            ST_J:       cmd.op = OP_RD_J;
            ST_DIFF:    cmd.op = OP_DIFF;
            ST_SQ_X:    cmd.op = OP_SQ_X;
            ST_SQ_Y:    cmd.op = OP_SQ_Y;
            ST_D2:      cmd.op = OP_D2;
            ST_N_X:     cmd.op = stat.skip ? OP_IDLE : OP_N_X;
            ST_N_Y:     cmd.op = OP_N_Y;
            ST_ACC:     cmd.op = OP_ACC;
            ST_BOUNCE:  cmd.op = OP_BOUNCE;
            ST_EMIT:    cmd.op = slot_free ? OP_EMIT : OP_IDLE;
            default:    cmd.op = OP_IDLE;
        endcase
    end

    assign addr    = (state_reg == ST_J) ? j_reg : i_reg;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== design/nbody_gravity_wall_step_top.sv =====
// Top level of the n-body gravity step block with arena wall bounces.
// Load item: written in the cycle it is accepted, next item accepted at once.
// Step item: gain times step first, then per body a fetch and a move; for each pulling pair
// the pair geometry and two restoring dividers, for each close pair the geometry only,
// a pass over itself, then the bounce and the emit.
// One item at a time; emit waits on a held result. Reset restores config and control, not body stores.
`default_nettype none

module nbody_gravity_wall_step_top
    import nbgws_pkg::*;
#(
    parameter int MAX_BODIES = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_operation,
    input  wire logic [3:0]         s_body_index,
    input  wire logic [7:0]         s_body_radius,
    input  wire logic [31:0]        s_body_mass,
    input  wire logic signed [31:0] s_start_x,
    input  wire logic signed [31:0] s_start_y,
    input  wire logic signed [31:0] s_start_vx,
    input  wire logic signed [31:0] s_start_vy,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [3:0]              m_out_index,
    output logic signed [31:0]      m_out_x,
    output logic signed [31:0]      m_out_y,
    output logic                    m_last_body
);

    dp_cmd_t                       cmd;
    dp_stat_t                      stat;
    logic [$clog2(MAX_BODIES)-1:0] addr;

    assign cfg_ready = 1'b1;

    nbgws_ctrl #(.MAX_BODIES(MAX_BODIES)) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .addr        (addr),
        .stat        (stat)
    );

    nbgws_dp #(.MAX_BODIES(MAX_BODIES)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .addr          (addr),
        .stat          (stat),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_body_index  (s_body_index),
        .s_body_radius (s_body_radius),
        .s_body_mass   (s_body_mass),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_start_vx    (s_start_vx),
        .s_start_vy    (s_start_vy),
        .m_out_index   (m_out_index),
        .m_out_x       (m_out_x),
        .m_out_y       (m_out_y),
        .m_last_body   (m_last_body)
    );

    // A pending result while the block is idle must close a step
    a_idle_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && m_valid |-> m_last_body)
        else $error("idle with a non-final result pending");

    // A fresh non-final result means the step is still running
    a_mid_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) && !m_last_body |-> !s_ready)
        else $error("input ready in the middle of a step");

    // Result index stays within the body store
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_out_index) < MAX_BODIES))
        else $error("result index beyond the body store");

endmodule

`default_nettype wire
